FILE: rtl/core/gpc_pkg.sv
// ----------------------------------------------------------------------------
// gpc_pkg
// Shared types, constants and helper functions for the GPIO pin controller.
// ----------------------------------------------------------------------------
package gpc_pkg;

    localparam int NUM_PINS    = 54;
    localparam int FIELD_W     = 54;
    localparam int DATA_W      = 32;
    localparam int OFF_W       = 6;
    localparam int FUNC_W      = 3;
    localparam int PINS_PER_FS = 10;
    localparam int FSEL_BITS   = PINS_PER_FS * FUNC_W;
    localparam int FSEL_WORDS  = (NUM_PINS + PINS_PER_FS - 1) / PINS_PER_FS;
    localparam int FSEL_IDX_W  = (FSEL_WORDS > 1) ? $clog2(FSEL_WORDS) : 1;
    localparam int PULL_W      = 2;

    localparam logic [OFF_W-1:0] OFF_FSEL_LAST = 6'd5;
    localparam logic [OFF_W-1:0] OFF_SET0      = 6'(8'h1c >> 2);
    localparam logic [OFF_W-1:0] OFF_SET1      = 6'(8'h1c >> 2) + 6'd1;
    localparam logic [OFF_W-1:0] OFF_CLR0      = 6'(8'h28 >> 2);
    localparam logic [OFF_W-1:0] OFF_CLR1      = 6'(8'h28 >> 2) + 6'd1;
    localparam logic [OFF_W-1:0] OFF_LEV0      = 6'(8'h34 >> 2);
    localparam logic [OFF_W-1:0] OFF_LEV1      = 6'(8'h34 >> 2) + 6'd1;
    localparam logic [OFF_W-1:0] OFF_PUD       = 6'(8'h94 >> 2);
    localparam logic [OFF_W-1:0] OFF_PUDCLK0   = 6'(8'h98 >> 2);
    localparam logic [OFF_W-1:0] OFF_PUDCLK1   = 6'(8'h9c >> 2);

    localparam logic [FUNC_W-1:0] FUNC_OUTPUT = 3'd1;
    localparam logic [PULL_W-1:0] PULL_DOWN   = 2'd1;
    localparam logic [PULL_W-1:0] PULL_UP     = 2'd2;

    typedef logic [NUM_PINS-1:0]  pins_t;
    typedef logic [FIELD_W-1:0]   field_t;
    typedef logic [FSEL_BITS-1:0] fsel_word_t;

    typedef struct packed {
        logic                 valid;
        logic                 wr;
        logic [OFF_W-1:0]     off;
        logic [DATA_W-1:0]    data;
        field_t               levels;
    } gpc_access_t;

    function automatic field_t to_field(input pins_t v);
        logic [63:0] p;
        begin
            p = 64'(v);
            return p[FIELD_W-1:0];
        end
    endfunction

    function automatic pins_t to_pins(input field_t v);
        logic [63:0] p;
        begin
            p = 64'(v);
            return p[NUM_PINS-1:0];
        end
    endfunction

    function automatic pins_t bank_mask(input logic bank, input logic [DATA_W-1:0] data);
        logic [63:0] p;
        begin
            p = bank ? {data, 32'h0} : {32'h0, data};
            return p[NUM_PINS-1:0];
        end
    endfunction

    function automatic fsel_word_t fsel_mask(input logic [FSEL_IDX_W-1:0] idx);
        fsel_word_t m;
        int         base;
        begin
            m    = '0;
            base = int'(idx) * PINS_PER_FS;
            for (int k = 0; k < PINS_PER_FS; k++) begin
                if (base + k < NUM_PINS) begin
                    m[k*FUNC_W +: FUNC_W] = '1;
                end
            end
            return m;
        end
    endfunction

endpackage

FILE: rtl/core/gpc_regs.sv
// ----------------------------------------------------------------------------
// gpc_regs
// Register file of the GPIO controller: decodes one access, updates the
// function select, output latch and pull state, and returns the read data.
// ----------------------------------------------------------------------------
module gpc_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  gpc_pkg::gpc_access_t        acc,
    output logic [gpc_pkg::DATA_W-1:0]  rd_data,
    output gpc_pkg::field_t             drive_levels,
    output gpc_pkg::field_t             drive_enables,
    output gpc_pkg::field_t             pullup_pins,
    output gpc_pkg::field_t             pulldown_pins
);
    import gpc_pkg::*;

    fsel_word_t            fsel_reg  [FSEL_WORDS];
    fsel_word_t            fsel_next [FSEL_WORDS];
    pins_t                 latch_reg, latch_next;
    logic [PULL_W-1:0]     pull_reg, pull_next;
    pins_t                 up_reg, up_next;
    pins_t                 down_reg, down_next;
    pins_t                 enables;
    pins_t                 mask;
    pins_t                 levels;
    logic [63:0]           lev_wide;
    logic [FSEL_IDX_W-1:0] idx;

    assign idx      = acc.off[FSEL_IDX_W-1:0];
    assign levels   = to_pins(acc.levels);
    assign lev_wide = 64'(to_field(levels));

    always_comb
    begin
        fsel_next  = fsel_reg;
        latch_next = latch_reg;
        pull_next  = pull_reg;
        up_next    = up_reg;
        down_next  = down_reg;
        rd_data    = '0;
        mask       = bank_mask(acc.off == OFF_SET1 || acc.off == OFF_CLR1
                               || acc.off == OFF_PUDCLK1, acc.data);
        if (acc.valid)
        begin
            if (acc.off <= OFF_FSEL_LAST)
            begin
                if (acc.off < OFF_W'(FSEL_WORDS))
                begin
                    if (acc.wr)
                        fsel_next[idx] = acc.data[FSEL_BITS-1:0] & fsel_mask(idx);
                    else
                        rd_data = DATA_W'(fsel_reg[idx]);
                end
            end
            else if (acc.off == OFF_SET0 || acc.off == OFF_SET1)
            begin
                if (acc.wr)
                    latch_next = latch_reg | mask;
            end
            else if (acc.off == OFF_CLR0 || acc.off == OFF_CLR1)
            begin
                if (acc.wr)
                    latch_next = latch_reg & ~mask;
            end
            else if (acc.off == OFF_LEV0 || acc.off == OFF_LEV1)
            begin
                if (!acc.wr)
                    rd_data = (acc.off == OFF_LEV1) ? lev_wide[63:32] : lev_wide[31:0];
            end
            else if (acc.off == OFF_PUD)
            begin
                if (acc.wr)
                    pull_next = acc.data[PULL_W-1:0];
                else
                    rd_data = DATA_W'(pull_reg);
            end
            else if (acc.off == OFF_PUDCLK0 || acc.off == OFF_PUDCLK1)
            begin
                if (acc.wr)
                begin
                    up_next   = (up_reg & ~mask) | ((pull_reg == PULL_UP) ? mask : '0);
                    down_next = (down_reg & ~mask) | ((pull_reg == PULL_DOWN) ? mask : '0);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < FSEL_WORDS; w++)
                fsel_reg[w] <= '0;
            latch_reg <= '0;
            pull_reg  <= '0;
            up_reg    <= '0;
            down_reg  <= '0;
        end
        else
        begin
            fsel_reg  <= fsel_next;
            latch_reg <= latch_next;
            pull_reg  <= pull_next;
            up_reg    <= up_next;
            down_reg  <= down_next;
        end
    end

    for (genvar i = 0; i < NUM_PINS; i++)
    begin : g_en
        localparam int W = i / PINS_PER_FS;
        localparam int B = (i % PINS_PER_FS) * FUNC_W;
        assign enables[i] = (fsel_reg[W][B +: FUNC_W] == FUNC_OUTPUT);
    end

    assign drive_levels  = to_field(latch_reg);
    assign drive_enables = to_field(enables);
    assign pullup_pins   = to_field(up_reg);
    assign pulldown_pins = to_field(down_reg);

endmodule

FILE: rtl/core/gpio_pin_controller_unit.sv
// ----------------------------------------------------------------------------
// gpio_pin_controller_unit
// Memory-mapped GPIO controller: one register read or write per beat, with
// the pin-side latch state reported after every access.
// ----------------------------------------------------------------------------
//  channel   | handshake             | payload
//  ----------+-----------------------+--------------------------------------
//  request   | start / busy          | req_type word_offset write_value
//            |                       | pin_levels_in
//  result    | done (one-cycle)      | read_value drive_levels drive_enables
//            |                       | pullup_pins pulldown_pins
//
//  one beat per cycle; busy is never raised
//  result path: the request is captured in the input register, then decode
//  and register update write the result register (done, read_value) and the
//  state registers that drive the pin-side outputs
//  rst_n clears function select, output latch and pull state
//  the receiver cannot stall; done is a single-cycle strobe
// ----------------------------------------------------------------------------
module gpio_pin_controller_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        req_type,
    input  logic [gpc_pkg::OFF_W-1:0]   word_offset,
    input  logic [gpc_pkg::DATA_W-1:0]  write_value,
    input  gpc_pkg::field_t             pin_levels_in,
    output logic                        done,
    output logic [gpc_pkg::DATA_W-1:0]  read_value,
    output gpc_pkg::field_t             drive_levels,
    output gpc_pkg::field_t             drive_enables,
    output gpc_pkg::field_t             pullup_pins,
    output gpc_pkg::field_t             pulldown_pins
);
    import gpc_pkg::*;

    logic                req_valid_reg;
    logic                req_type_reg;
    logic [OFF_W-1:0]    req_off_reg;
    logic [DATA_W-1:0]   req_data_reg;
    field_t              req_levels_reg;
    gpc_access_t         acc;
    logic [DATA_W-1:0]   rd_data;
    logic                done_reg;
    logic [DATA_W-1:0]   read_value_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            req_valid_reg <= start;
            done_reg      <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            req_type_reg   <= req_type;
            req_off_reg    <= word_offset;
            req_data_reg   <= write_value;
            req_levels_reg <= pin_levels_in;
        end
        if (req_valid_reg)
            read_value_reg <= req_type_reg ? '0 : rd_data;
    end

    assign acc.valid  = req_valid_reg;
    assign acc.wr     = req_type_reg;
    assign acc.off    = req_off_reg;
    assign acc.data   = req_data_reg;
    assign acc.levels = req_levels_reg;

    gpc_regs u_regs (
        .clk           (clk),
        .rst_n         (rst_n),
        .acc           (acc),
        .rd_data       (rd_data),
        .drive_levels  (drive_levels),
        .drive_enables (drive_enables),
        .pullup_pins   (pullup_pins),
        .pulldown_pins (pulldown_pins)
    );

    assign done       = done_reg;
    assign read_value = read_value_reg;

`ifndef ASSERT_OFF
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid_reg |=> done)
        else $error("result strobe missing after access");

    a_write_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid_reg && req_type_reg) |=> (read_value == '0))
        else $error("write access returned nonzero read data");

    a_pull_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        ((pullup_pins & pulldown_pins) == '0))
        else $error("pin latched both pull-up and pull-down");

    a_latch_on_beat: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(drive_levels) |-> done)
        else $error("output latch changed without an access");
`endif

endmodule

FILE: test/gpio_pin_controller_unit_test.sv
// ----------------------------------------------------------------------------
// gpio_pin_controller_unit_test
// Self-checking bench for the GPIO pin controller. Register reads and writes
// are driven one beat at a time, with random gaps save in one run. A scoreboard
// keeps its own copy of the function selects, output latch and pull state. It
// checks read data and every pin-side snapshot against the block's results.
// ----------------------------------------------------------------------------
module gpio_pin_controller_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import gpc_pkg::*;

    localparam bit                ACC_READ   = 1'b0;
    localparam bit                ACC_WRITE  = 1'b1;
    localparam logic [OFF_W-1:0]  OFF_HOLE   = 6'd6;
    localparam logic [OFF_W-1:0]  OFF_TOP    = 6'd63;
    localparam logic [PULL_W-1:0] PULL_OFF   = 2'd0;
    localparam logic [PULL_W-1:0] PULL_RSVD  = 2'd3;
    localparam int RANDOM_BEATS  = 1950;
    localparam int CYCLE_LIMIT   = 40000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int PRINT_LIMIT   = 40;

    typedef struct {
        logic [DATA_W-1:0] rd;
        field_t            levels;
        field_t            enables;
        field_t            ups;
        field_t            downs;
    } pin_snapshot_t;

    class pin_state_scoreboard;
        logic [FUNC_W-1:0] func_sel [NUM_PINS];
        pins_t             out_latch;
        pins_t             up_latch;
        pins_t             down_latch;
        logic [PULL_W-1:0] pull_sel;
        pin_snapshot_t     expected_q [$];
        int                errors;
        int                checked;
        int                reads;
        int                writes;

        function new();
            foreach (func_sel[i])
                func_sel[i] = '0;
            out_latch  = '0;
            up_latch   = '0;
            down_latch = '0;
            pull_sel   = PULL_OFF;
            errors     = 0;
            checked    = 0;
            reads      = 0;
            writes     = 0;
        endfunction

        function pins_t bank_bits(bit hi, logic [DATA_W-1:0] d);
            logic [63:0] w;
            w = hi ? {d, 32'h0} : {32'h0, d};
            return w[NUM_PINS-1:0];
        endfunction

        function void note_access(bit wr, logic [OFF_W-1:0] off, logic [DATA_W-1:0] data,
                                  field_t lev);
            pin_snapshot_t s;
            logic [63:0]   lv;
            pins_t         m;
            int            pin;
            s.rd = '0;
            if (off <= OFF_FSEL_LAST)
            begin
                for (int k = 0; k < PINS_PER_FS; k++)
                begin
                    pin = int'(off) * PINS_PER_FS + k;
                    if (pin < NUM_PINS)
                    begin
                        if (wr)
                            func_sel[pin] = data[k*FUNC_W +: FUNC_W];
                        else
                            s.rd[k*FUNC_W +: FUNC_W] = func_sel[pin];
                    end
                end
            end
            else if (off == OFF_SET0 || off == OFF_SET1)
            begin
                if (wr)
                    out_latch |= bank_bits(off == OFF_SET1, data);
            end
            else if (off == OFF_CLR0 || off == OFF_CLR1)
            begin
                if (wr)
                    out_latch &= ~bank_bits(off == OFF_CLR1, data);
            end
            else if (off == OFF_LEV0 || off == OFF_LEV1)
            begin
                if (!wr)
                begin
                    lv = 64'(lev);
                    s.rd = (off == OFF_LEV1) ? lv[63:32] : lv[31:0];
                end
            end
            else if (off == OFF_PUD)
            begin
                if (wr)
                    pull_sel = data[PULL_W-1:0];
                else
                    s.rd = DATA_W'(pull_sel);
            end
            else if (off == OFF_PUDCLK0 || off == OFF_PUDCLK1)
            begin
                if (wr)
                begin
                    m = bank_bits(off == OFF_PUDCLK1, data);
                    up_latch   &= ~m;
                    down_latch &= ~m;
                    // reserved code behaves as off
                    if (pull_sel == PULL_UP)
                        up_latch |= m;
                    else if (pull_sel == PULL_DOWN)
                        down_latch |= m;
                end
            end
            s.enables = '0;
            for (int i = 0; i < NUM_PINS; i++)
                s.enables[i] = (func_sel[i] == FUNC_OUTPUT);
            s.levels = field_t'(out_latch);
            s.ups    = field_t'(up_latch);
            s.downs  = field_t'(down_latch);
            expected_q.push_back(s);
            if (wr)
                writes++;
            else
                reads++;
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            if (errors <= PRINT_LIMIT)
                $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
        endtask

        task check_result(pin_snapshot_t got);
            pin_snapshot_t e;
            if (expected_q.size() == 0)
            begin
                report("result with none pending", 64'(got.rd), 64'h0);
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (got.rd !== e.rd)
                report("read_value", 64'(got.rd), 64'(e.rd));
            if (got.levels !== e.levels)
                report("drive_levels", 64'(got.levels), 64'(e.levels));
            if (got.enables !== e.enables)
                report("drive_enables", 64'(got.enables), 64'(e.enables));
            if (got.ups !== e.ups)
                report("pullup_pins", 64'(got.ups), 64'(e.ups));
            if (got.downs !== e.downs)
                report("pulldown_pins", 64'(got.downs), 64'(e.downs));
        endtask
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              req_type = 1'b0;
    logic [OFF_W-1:0]  word_offset = '0;
    logic [DATA_W-1:0] write_value = '0;
    field_t            pin_levels_in = '0;
    logic              busy;
    logic              done;
    logic [DATA_W-1:0] read_value;
    field_t            drive_levels;
    field_t            drive_enables;
    field_t            pullup_pins;
    field_t            pulldown_pins;

    pin_state_scoreboard sb = new();
    bit gaps_on = 1'b1;
    int cycles = 0;

    gpio_pin_controller_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .word_offset   (word_offset),
        .write_value   (write_value),
        .pin_levels_in (pin_levels_in),
        .done          (done),
        .read_value    (read_value),
        .drive_levels  (drive_levels),
        .drive_enables (drive_enables),
        .pullup_pins   (pullup_pins),
        .pulldown_pins (pulldown_pins)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin : result_monitor
        pin_snapshot_t got;
        if (rst_n && done === 1'b1)
        begin
            got.rd      = read_value;
            got.levels  = drive_levels;
            got.enables = drive_enables;
            got.ups     = pullup_pins;
            got.downs   = pulldown_pins;
            sb.check_result(got);
        end
    end

    task automatic send_beat(bit wr, logic [OFF_W-1:0] off, logic [DATA_W-1:0] data,
                             field_t lev);
        start         <= 1'b1;
        req_type      <= wr;
        word_offset   <= off;
        write_value   <= data;
        pin_levels_in <= lev;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        sb.note_access(wr, off, data, lev);
        if (gaps_on)
        begin
            while ($urandom_range(0, 99) < 29)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        end
    endtask

    function automatic field_t rand_levels();
        return field_t'({$urandom, $urandom});
    endfunction

    function automatic logic [DATA_W-1:0] rand_fsel_word();
        logic [DATA_W-1:0] w;
        w = $urandom;
        // lean toward output codes so enables move
        for (int k = 0; k < PINS_PER_FS; k++)
            if ($urandom_range(0, 9) < 4)
                w[k*FUNC_W +: FUNC_W] = FUNC_OUTPUT;
        return w;
    endfunction

    function automatic logic [OFF_W-1:0] pick_offset();
        if ($urandom_range(0, 99) < 12)
            return OFF_W'($urandom_range(0, 63));
        case ($urandom_range(0, 15))
            0, 1, 2: return OFF_W'($urandom_range(0, int'(OFF_FSEL_LAST)));
            3:       return OFF_SET0;
            4:       return OFF_SET1;
            5:       return OFF_CLR0;
            6:       return OFF_CLR1;
            7:       return OFF_LEV0;
            8:       return OFF_LEV1;
            9, 10:   return OFF_PUD;
            11, 12:  return OFF_PUDCLK0;
            13, 14:  return OFF_PUDCLK1;
            default: return OFF_HOLE;
        endcase
    endfunction

    task automatic send_random_beat();
        logic [OFF_W-1:0]  off;
        logic [DATA_W-1:0] data;
        bit                wr;
        off = pick_offset();
        wr  = ($urandom_range(0, 99) < 55) ? ACC_WRITE : ACC_READ;
        case ($urandom_range(0, 9))
            0:       data = '1;
            1:       data = '0;
            default: data = (off <= OFF_FSEL_LAST) ? rand_fsel_word() : DATA_W'($urandom);
        endcase
        send_beat(wr, off, data, rand_levels());
    endtask

    initial
    begin
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values, then every fsel word at full scale
        send_beat(ACC_READ,  6'd0,          '1,           '1);
        for (int w = 0; w <= int'(OFF_FSEL_LAST); w++)
            send_beat(ACC_WRITE, OFF_W'(w), '1, '0);
        send_beat(ACC_READ,  6'd0,          '0,           '0);
        send_beat(ACC_READ,  OFF_FSEL_LAST, '0,           '0);
        send_beat(ACC_WRITE, 6'd0,          32'h0924_9249, '0);
        send_beat(ACC_WRITE, OFF_SET0,      '1,           '0);
        send_beat(ACC_WRITE, OFF_SET1,      '1,           '0);
        send_beat(ACC_READ,  OFF_SET1,      '1,           '1);
        send_beat(ACC_WRITE, OFF_CLR0,      '1,           '0);
        send_beat(ACC_WRITE, OFF_CLR1,      32'h0000_aaaa, '0);
        send_beat(ACC_READ,  OFF_LEV0,      '0,           '1);
        send_beat(ACC_READ,  OFF_LEV1,      '0,           '1);
        send_beat(ACC_WRITE, OFF_LEV0,      '1,           '1);
        send_beat(ACC_WRITE, OFF_PUD,       DATA_W'(PULL_UP),   '0);
        send_beat(ACC_WRITE, OFF_PUDCLK0,   '1,           '0);
        send_beat(ACC_WRITE, OFF_PUD,       32'hffff_fffd, '0);
        send_beat(ACC_WRITE, OFF_PUDCLK1,   '1,           '0);
        send_beat(ACC_WRITE, OFF_PUD,       DATA_W'(PULL_RSVD), '0);
        send_beat(ACC_READ,  OFF_PUD,       '0,           '0);
        send_beat(ACC_WRITE, OFF_PUDCLK0,   32'h0000_ffff, '0);
        send_beat(ACC_WRITE, OFF_PUDCLK1,   '0,           '0);
        send_beat(ACC_WRITE, OFF_TOP,       '1,           '1);
        send_beat(ACC_READ,  OFF_TOP,       '1,           '1);

        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            gaps_on = !(n >= 700 && n < 1000);
            send_random_beat();
        end
        start <= 1'b0;

        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("covered %0d register reads and %0d writes over fsel, set, clear, level,",
                 sb.reads, sb.writes);
        $display("pull and unmapped words; %0d results checked, %0d mismatches",
                 sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/gpc_pkg.sv
rtl/core/gpc_regs.sv
rtl/core/gpio_pin_controller_unit.sv
test/gpio_pin_controller_unit_test.sv
